@@ src/gmps_pkg.sv @@
// Shared constants for the grid maze path search block.
// Used by grid_maze_path_search; has no dependencies of its own.
`timescale 1ns / 1ps
package gmps_pkg;
  localparam int MAX_DIM = 64;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CELL_W  = 2 * DIM_W;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int CNT_W   = CELL_W + 1;
  localparam int LABEL_W = 13;
  localparam int CFG_W   = 7;

  localparam logic [CNT_W-1:0] STACK_FULL = CNT_W'(CELLS);
  localparam logic [CFG_W-1:0] DIM_RESET  = CFG_W'(MAX_DIM);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic CFG_HEIGHT = 1'b0;
  localparam logic CFG_WIDTH  = 1'b1;

  // Zero acts as one, anything above the grid storage saturates.
  function automatic logic [CFG_W-1:0] dim_in_use(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) r = CFG_W'(1);
    else if (v > DIM_RESET) r = DIM_RESET;
    return r;
  endfunction
endpackage

@@ src/grid_maze_path_search.sv @@
// Grid maze path search: wall, label and stack memories plus the walk sequencer.
// Depends on gmps_pkg and gmps_ram.
//
//   channel | ports                                  | flow
//   --------+----------------------------------------+--------------------------
//   input   | start, busy, in_*                      | request taken on start & !busy
//   result  | out_valid, out_reached, out_label      | one-cycle strobe, no stall
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | taken on valid & ready
//
// After reset a clearing pass zeroes walls and labels; busy is high.
// Writes and unused commands answer the cycle after acceptance; reads pass S_RD.
// A solve clears all labels through the single label write port, answers not
// reached if the start is off the grid, else seeds it; per stack top it runs
// S_POP, S_TOP, S_W0-S_W3, S_NB per neighbor (S_NBC if open) and S_END, ending
// on the target on top or an empty stack. The receiver cannot stall results.
`timescale 1ns / 1ps
module grid_maze_path_search (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_command,
  input  logic [gmps_pkg::DIM_W-1:0]  in_row,
  input  logic [gmps_pkg::DIM_W-1:0]  in_col,
  input  logic                        in_right_wall,
  input  logic                        in_down_wall,
  input  logic [gmps_pkg::DIM_W-1:0]  in_target_row,
  input  logic [gmps_pkg::DIM_W-1:0]  in_target_col,
  output logic                        out_valid,
  output logic                        out_reached,
  output logic signed [gmps_pkg::LABEL_W-1:0] out_label,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [gmps_pkg::CFG_W-1:0]  cfg_data
);
  localparam int DW = gmps_pkg::DIM_W;
  localparam int CW = gmps_pkg::CELL_W;
  localparam int NW = gmps_pkg::CNT_W;
  localparam int LW = gmps_pkg::LABEL_W;
  localparam int FW = gmps_pkg::CFG_W;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_SCLR = 4'd3;
  localparam logic [3:0] S_SEED = 4'd4;
  localparam logic [3:0] S_POP  = 4'd5;
  localparam logic [3:0] S_TOP  = 4'd6;
  localparam logic [3:0] S_W0   = 4'd7;
  localparam logic [3:0] S_W1   = 4'd8;
  localparam logic [3:0] S_W2   = 4'd9;
  localparam logic [3:0] S_W3   = 4'd10;
  localparam logic [3:0] S_NB   = 4'd11;
  localparam logic [3:0] S_NBC  = 4'd12;
  localparam logic [3:0] S_END  = 4'd13;

  logic [3:0]    state_r, state_nxt;
  logic [FW-1:0] height_r, width_r;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cur_r, cur_nxt;
  logic [CW-1:0] start_cell_r, start_cell_nxt;
  logic [DW-1:0] trow_r, trow_nxt, tcol_r, tcol_nxt;
  logic [LW-1:0] dist_r, dist_nxt;
  logic          rw_c_r, rw_c_nxt, dw_c_r, dw_c_nxt, rw_l_r, rw_l_nxt, dw_u_r, dw_u_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          pushed_r, pushed_nxt;
  logic          ov_r, ov_nxt, orch_r, orch_nxt;
  logic [LW-1:0] olab_r, olab_nxt;

  logic          wall_we;
  logic [CW-1:0] wall_waddr, wall_raddr;
  logic [1:0]    wall_wdata, wall_rdata;
  logic          lab_we;
  logic [CW-1:0] lab_waddr, lab_raddr;
  logic [LW-1:0] lab_wdata, lab_rdata;
  logic          stk_we;
  logic [CW-1:0] stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic [FW-1:0] h_eff, w_eff;
  logic [DW-1:0] cur_y, cur_x;
  logic          accept, nb_open;
  logic [CW-1:0] nb_addr;

  gmps_ram #(.WIDTH(2), .DEPTH(gmps_pkg::CELLS)) u_wall_ram (
    .clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(wall_wdata),
    .raddr(wall_raddr), .rdata(wall_rdata));
  gmps_ram #(.WIDTH(LW), .DEPTH(gmps_pkg::CELLS)) u_label_ram (
    .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
    .raddr(lab_raddr), .rdata(lab_rdata));
  gmps_ram #(.WIDTH(CW), .DEPTH(gmps_pkg::CELLS)) u_stack_ram (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata));

  assign busy        = (state_r != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready   = 1'b1;
  assign out_valid   = ov_r;
  assign out_reached = orch_r;
  assign out_label   = olab_r;
  assign h_eff       = gmps_pkg::dim_in_use(height_r);
  assign w_eff       = gmps_pkg::dim_in_use(width_r);
  assign cur_y       = cur_r[CW-1:DW];
  assign cur_x       = cur_r[DW-1:0];

  // Neighbor order is right, left, up, down.
  always_comb begin
    nb_open = 1'b0;
    nb_addr = cur_r;
    case (k_r)
      2'd0: begin
        nb_open = !rw_c_r && ((FW'(cur_x) + FW'(1)) < w_eff);
        nb_addr = cur_r + CW'(1);
      end
      2'd1: begin
        nb_open = (cur_x != '0) && !rw_l_r;
        nb_addr = cur_r - CW'(1);
      end
      2'd2: begin
        nb_open = (cur_y != '0) && !dw_u_r;
        nb_addr = cur_r - CW'(gmps_pkg::MAX_DIM);
      end
      default: begin
        nb_open = !dw_c_r && ((FW'(cur_y) + FW'(1)) < h_eff);
        nb_addr = cur_r + CW'(gmps_pkg::MAX_DIM);
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    start_cell_nxt = start_cell_r;
    trow_nxt = trow_r;
    tcol_nxt = tcol_r;
    dist_nxt = dist_r;
    rw_c_nxt = rw_c_r;
    dw_c_nxt = dw_c_r;
    rw_l_nxt = rw_l_r;
    dw_u_nxt = dw_u_r;
    k_nxt = k_r;
    pushed_nxt = pushed_r;
    ov_nxt = 1'b0;
    orch_nxt = 1'b0;
    olab_nxt = '0;
    wall_we = 1'b0;
    wall_waddr = {in_row, in_col};
    wall_wdata = {in_right_wall, in_down_wall};
    wall_raddr = cur_r;
    lab_we = 1'b0;
    lab_waddr = clr_r;
    lab_wdata = '0;
    lab_raddr = cur_r;
    stk_we = 1'b0;
    stk_waddr = cnt_r[CW-1:0];
    stk_wdata = nb_addr;
    stk_raddr = cnt_r[CW-1:0] - CW'(1);

    unique case (state_r)
      S_CLR: begin
        wall_we = 1'b1;
        wall_waddr = clr_r;
        wall_wdata = '0;
        lab_we = 1'b1;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == {CW{1'b1}}) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        lab_raddr = {in_row, in_col};
        if (accept) begin
          case (in_command)
            gmps_pkg::CMD_WRITE: begin
              wall_we = 1'b1;
              ov_nxt = 1'b1;
            end
            gmps_pkg::CMD_SOLVE: begin
              start_cell_nxt = {in_row, in_col};
              trow_nxt = in_target_row;
              tcol_nxt = in_target_col;
              clr_nxt = '0;
              cnt_nxt = '0;
              state_nxt = S_SCLR;
            end
            gmps_pkg::CMD_READ: state_nxt = S_RD;
            default: ov_nxt = 1'b1;
          endcase
        end
      end
      S_RD: begin
        ov_nxt = 1'b1;
        olab_nxt = lab_rdata;
        state_nxt = S_IDLE;
      end
      S_SCLR: begin
        lab_we = 1'b1;
        clr_nxt = clr_r + CW'(1);
        if (clr_r == {CW{1'b1}}) begin
          if ((FW'(start_cell_r[CW-1:DW]) >= h_eff) ||
              (FW'(start_cell_r[DW-1:0]) >= w_eff)) begin
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_SEED;
          end
        end
      end
      S_SEED: begin
        lab_we = 1'b1;
        lab_waddr = start_cell_r;
        lab_wdata = {LW{1'b1}};
        stk_we = 1'b1;
        stk_waddr = '0;
        stk_wdata = start_cell_r;
        cnt_nxt = NW'(1);
        state_nxt = S_POP;
      end
      S_POP: state_nxt = S_TOP;
      S_TOP: begin
        cur_nxt = stk_rdata;
        lab_raddr = stk_rdata;
        if (stk_rdata == {trow_r, tcol_r}) begin
          ov_nxt = 1'b1;
          orch_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_W0;
        end
      end
      S_W0: begin
        dist_nxt = lab_rdata[LW-1] ? '0 : lab_rdata;
        wall_raddr = cur_r;
        state_nxt = S_W1;
      end
      S_W1: begin
        rw_c_nxt = wall_rdata[1];
        dw_c_nxt = wall_rdata[0];
        wall_raddr = cur_r - CW'(1);
        state_nxt = S_W2;
      end
      S_W2: begin
        rw_l_nxt = wall_rdata[1];
        wall_raddr = cur_r - CW'(gmps_pkg::MAX_DIM);
        state_nxt = S_W3;
      end
      S_W3: begin
        dw_u_nxt = wall_rdata[0];
        k_nxt = '0;
        pushed_nxt = 1'b0;
        state_nxt = S_NB;
      end
      S_NB: begin
        lab_raddr = nb_addr;
        if (nb_open) state_nxt = S_NBC;
        else if (k_r == 2'd3) state_nxt = S_END;
        else k_nxt = k_r + 2'd1;
      end
      S_NBC: begin
        if ((lab_rdata == '0) && (cnt_r < gmps_pkg::STACK_FULL)) begin
          lab_we = 1'b1;
          lab_waddr = nb_addr;
          lab_wdata = dist_r + LW'(1);
          stk_we = 1'b1;
          cnt_nxt = cnt_r + NW'(1);
          pushed_nxt = 1'b1;
        end
        if (k_r == 2'd3) state_nxt = S_END;
        else begin
          k_nxt = k_r + 2'd1;
          state_nxt = S_NB;
        end
      end
      S_END: begin
        if (!pushed_r) begin
          cnt_nxt = cnt_r - NW'(1);
          if (cnt_r == NW'(1)) begin
            ov_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_POP;
          end
        end else begin
          state_nxt = S_POP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      clr_r    <= '0;
      cnt_r    <= '0;
      k_r      <= '0;
      pushed_r <= 1'b0;
      ov_r     <= 1'b0;
      orch_r   <= 1'b0;
      olab_r   <= '0;
      height_r <= gmps_pkg::DIM_RESET;
      width_r  <= gmps_pkg::DIM_RESET;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      cnt_r    <= cnt_nxt;
      k_r      <= k_nxt;
      pushed_r <= pushed_nxt;
      ov_r     <= ov_nxt;
      orch_r   <= orch_nxt;
      olab_r   <= olab_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == gmps_pkg::CFG_HEIGHT) height_r <= cfg_data;
        if (cfg_index == gmps_pkg::CFG_WIDTH) width_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    start_cell_r <= start_cell_nxt;
    trow_r       <= trow_nxt;
    tcol_r       <= tcol_nxt;
    dist_r       <= dist_nxt;
    rw_c_r       <= rw_c_nxt;
    dw_c_r       <= dw_c_nxt;
    rw_l_r       <= rw_l_nxt;
    dw_u_r       <= dw_u_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= gmps_pkg::STACK_FULL) else $error("stack count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> (cnt_r != '0)) else $error("pop from empty stack");
  a_quiet_out: assert property (@(posedge clk) disable iff (!rst_n)
    !ov_r |-> (!orch_r && (olab_r == '0))) else $error("result fields set without strobe");
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> $past(busy || start)) else $error("strobe without request");
endmodule

@@ src/gmps_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module gmps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for grid_maze_path_search: wall writes, solves and label reads.
// Depends on gmps_pkg and the block's RTL; a scoreboard class predicts each result.
`timescale 1ns / 1ps
module tb;
  localparam int DW = gmps_pkg::DIM_W;
  localparam int LW = gmps_pkg::LABEL_W;
  localparam int FW = gmps_pkg::CFG_W;
  localparam int NCELLS = gmps_pkg::CELLS;
  localparam int MAXD = gmps_pkg::MAX_DIM;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 20;

  class maze_scoreboard;
    typedef struct {
      logic                 reached;
      logic signed [LW-1:0] label;
    } maze_result_t;

    bit                   right_bits[NCELLS];
    bit                   down_bits[NCELLS];
    logic signed [LW-1:0] dist_labels[NCELLS];
    int unsigned          walk_stack[NCELLS];
    int unsigned          depth;
    int unsigned          rows_reg;
    int unsigned          cols_reg;
    maze_result_t         awaiting[$];

    function new();
      foreach (right_bits[i]) begin
        right_bits[i] = 0;
        down_bits[i] = 0;
        dist_labels[i] = '0;
      end
      depth = 0;
      rows_reg = MAXD;
      cols_reg = MAXD;
    endfunction

    function void write_reg(logic idx, logic [FW-1:0] v);
      if (idx == gmps_pkg::CFG_HEIGHT) rows_reg = int'(v);
      else cols_reg = int'(v);
    endfunction

    function int unsigned clamp_dim(int unsigned v);
      if (v == 0) return 1;
      if (v > MAXD) return MAXD;
      return v;
    endfunction

    function void mark_cell(int unsigned c, int d, ref bit pushed);
      if (dist_labels[c] != 0) return;
      if (depth >= NCELLS) return;
      dist_labels[c] = LW'(d);
      walk_stack[depth] = c;
      depth++;
      pushed = 1;
    endfunction

    function logic walk(int unsigned r, int unsigned c, int unsigned tr, int unsigned tc);
      int unsigned h, w, cur, y, x;
      int d;
      bit pushed;
      h = clamp_dim(rows_reg);
      w = clamp_dim(cols_reg);
      foreach (dist_labels[i]) dist_labels[i] = '0;
      depth = 0;
      if (r >= h || c >= w) return 1'b0;
      dist_labels[r * MAXD + c] = LW'(-1);
      walk_stack[0] = r * MAXD + c;
      depth = 1;
      while (depth > 0) begin
        cur = walk_stack[depth - 1] % NCELLS;
        y = cur / MAXD;
        x = cur % MAXD;
        pushed = 0;
        if (y == tr && x == tc) return 1'b1;
        d = (dist_labels[cur] < 0) ? 0 : int'(dist_labels[cur]);
        if (!right_bits[cur] && x + 1 < w) mark_cell(cur + 1, d + 1, pushed);
        if (x > 0 && !right_bits[cur - 1]) mark_cell(cur - 1, d + 1, pushed);
        if (y > 0 && !down_bits[cur - MAXD]) mark_cell(cur - MAXD, d + 1, pushed);
        if (!down_bits[cur] && y + 1 < h) mark_cell(cur + MAXD, d + 1, pushed);
        if (!pushed) depth--;
      end
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] cmd, int unsigned r, int unsigned c, bit rw, bit dw,
                               int unsigned tr, int unsigned tc);
      maze_result_t e;
      e.reached = 1'b0;
      e.label = '0;
      case (cmd)
        gmps_pkg::CMD_WRITE: begin
          right_bits[r * MAXD + c] = rw;
          down_bits[r * MAXD + c] = dw;
        end
        gmps_pkg::CMD_SOLVE: e.reached = walk(r, c, tr, tc);
        gmps_pkg::CMD_READ: e.label = dist_labels[r * MAXD + c];
        default: ;
      endcase
      awaiting = {awaiting, e};
    endfunction

    function string check_result(logic reached, logic signed [LW-1:0] label);
      maze_result_t e;
      if (awaiting.size() == 0) return "result with no request waiting";
      e = awaiting.pop_front();
      if (reached !== e.reached)
        return $sformatf("reached %b, expected %b", reached, e.reached);
      if (label !== e.label)
        return $sformatf("label %0d, expected %0d", label, e.label);
      return "";
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_command = '0;
  logic [DW-1:0] in_row = '0, in_col = '0, in_target_row = '0, in_target_col = '0;
  logic in_right_wall = 0, in_down_wall = 0;
  logic out_valid, out_reached;
  logic signed [LW-1:0] out_label;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = 0;
  logic [FW-1:0] cfg_data = '0;

  maze_scoreboard sb = new();
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;
  int sent = 0;

  grid_maze_path_search u_top (.*);

  always #5 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid) begin
      msg = sb.check_result(out_reached, out_label);
      if (msg != "") report_mismatch(msg);
    end
  end

  // Any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send(logic [1:0] cmd, int unsigned r, int unsigned c, bit rw, bit dw,
                      int unsigned tr, int unsigned tc);
    while ($urandom_range(99) < idle_pct) begin
      start = 0;
      @(negedge clk);
    end
    start = 1;
    in_command = cmd;
    in_row = DW'(r);
    in_col = DW'(c);
    in_right_wall = rw;
    in_down_wall = dw;
    in_target_row = DW'(tr);
    in_target_col = DW'(tc);
    do @(posedge clk); while (busy);
    sb.note_request(cmd, r, c, rw, dw, tr, tc);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 0;
    while (sb.awaiting.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Registers only change once every outstanding request has answered.
  task automatic set_grid(logic [FW-1:0] h, logic [FW-1:0] w);
    logic [FW-1:0] vals[2];
    wait_idle();
    vals[0] = h;
    vals[1] = w;
    for (int i = 0; i < 2; i++) begin
      cfg_valid = 1;
      cfg_index = (i == 0) ? gmps_pkg::CFG_HEIGHT : gmps_pkg::CFG_WIDTH;
      cfg_data = vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(cfg_index, cfg_data);
      @(negedge clk);
      cfg_valid = 0;
    end
  endtask

  // One well-formed maze: walls for every active cell, solves and reads, one random command.
  task automatic maze_run(int unsigned h, int unsigned w);
    int unsigned tr, tc;
    set_grid(FW'(h), FW'(w));
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        send(gmps_pkg::CMD_WRITE, r, c, $urandom_range(99) < 30, $urandom_range(99) < 30,
             $urandom_range(63), $urandom_range(63));
    repeat (2) begin
      tr = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(h - 1);
      tc = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(w - 1);
      send(gmps_pkg::CMD_SOLVE, $urandom_range(h - 1), $urandom_range(w - 1),
           1'($urandom_range(1)), 1'($urandom_range(1)), tr, tc);
      repeat (3)
        send(gmps_pkg::CMD_READ, $urandom_range(h - 1), $urandom_range(w - 1),
             1'($urandom_range(1)), 1'($urandom_range(1)),
             $urandom_range(63), $urandom_range(63));
    end
    send(2'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
         1'($urandom_range(1)), 1'($urandom_range(1)), $urandom_range(63),
         $urandom_range(63));
  endtask

  initial begin
    int phase;
    repeat (2) @(negedge clk);
    rst_n = 1;

    // Open full grid: the walk reaches the far corner, whose label is deep.
    send(gmps_pkg::CMD_SOLVE, 0, 0, 0, 0, 63, 63);
    send(gmps_pkg::CMD_READ, 63, 63, 0, 0, 0, 0);
    send(gmps_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send(gmps_pkg::CMD_READ, 0, 1, 1, 1, 63, 63);
    send(gmps_pkg::CMD_WRITE, 63, 63, 1, 1, 63, 63);
    send(gmps_pkg::CMD_WRITE, 0, 0, 1, 1, 0, 0);
    send(gmps_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0);
    send(CMD_UNUSED, 63, 63, 1, 1, 63, 63);
    // Zero rows acts as one; oversize columns saturate.
    set_grid(0, 127);
    send(gmps_pkg::CMD_SOLVE, 0, 5, 0, 0, 0, 63);
    send(gmps_pkg::CMD_READ, 0, 63, 0, 0, 0, 0);
    send(gmps_pkg::CMD_SOLVE, 1, 0, 0, 0, 0, 0);
    send(gmps_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    // Single-cell grid: start equals target, then target outside the grid.
    set_grid(1, 1);
    send(gmps_pkg::CMD_SOLVE, 0, 0, 0, 0, 0, 0);
    send(gmps_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send(gmps_pkg::CMD_SOLVE, 0, 0, 0, 0, 63, 0);
    send(gmps_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    set_grid(64, 64);
    send(gmps_pkg::CMD_WRITE, 0, 0, 1, 1, 0, 0);
    send(gmps_pkg::CMD_SOLVE, 0, 0, 0, 0, 1, 1);
    send(gmps_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
    send(gmps_pkg::CMD_WRITE, 0, 0, 0, 0, 0, 0);

    phase = 0;
    while (sent < 100) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 59;
        2: idle_pct = 0;
        default: idle_pct = 25;
      endcase
      maze_run($urandom_range(1, 4), $urandom_range(1, 4));
      phase++;
    end
    idle_pct = 0;
    wait_idle();
    if (mismatches == 0 && sb.awaiting.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
src/gmps_pkg.sv
src/gmps_ram.sv
src/grid_maze_path_search.sv
tb/tb.sv
